FILE: rtl/kmd_pkg.sv
// ----------------------------------------------------------------------------
// kmd_pkg
// Shared types, constants and helpers of the key matrix debounce reporter.
// ----------------------------------------------------------------------------
package kmd_pkg;

  // Matrix geometry
  localparam int MAX_ROWS = 4;
  localparam int MAX_COLS = 4;
  localparam int CELLS    = MAX_ROWS * MAX_COLS;
  localparam int ROW_W    = 2;
  localparam int COL_W    = 2;
  localparam int CELL_W   = 4;
  localparam int CNT_W    = 4;
  localparam int CHAR_W   = 8;
  localparam int DIM_W    = 3;
  localparam int MAP_W    = CELLS * CHAR_W;

  // Configuration register indexes
  localparam logic [2:0] REG_ROWS      = 3'd0;
  localparam logic [2:0] REG_COLS      = 3'd1;
  localparam logic [2:0] REG_LIMIT     = 3'd2;
  localparam logic [2:0] REG_CHAR_LOW  = 3'd3;
  localparam logic [2:0] REG_CHAR_HIGH = 3'd4;

  // Reset values of the configuration registers
  localparam logic [DIM_W-1:0] RST_ROWS      = 3'd3;
  localparam logic [DIM_W-1:0] RST_COLS      = 3'd3;
  localparam logic [CNT_W-1:0] RST_LIMIT     = 4'd6;
  localparam logic [63:0]      RST_CHAR_LOW  = 64'h6867_6665_6463_6261; // "abcdefgh"
  localparam logic [63:0]      RST_CHAR_HIGH = 64'h706F_6E6D_6C6B_6A69; // "ijklmnop"

  // Configuration as seen by the scan core (row and column counts clamped)
  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    logic [CNT_W-1:0] limit;
    logic [MAP_W-1:0] char_map;
  } cfg_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_UPDATE = 4'b0010,
    ST_CHECK  = 4'b0100,
    ST_WALK   = 4'b1000
  } state_t;

  // Clamp a row or column count into 1..hi
  function automatic logic [DIM_W-1:0] clamp_count(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > hi) begin
      res = hi;
    end
    return res;
  endfunction

  // Character of a logical cell index
  function automatic logic [CHAR_W-1:0] char_of(input logic [MAP_W-1:0]  map,
                                                input logic [CELL_W-1:0] idx);
    return map[{idx, 3'b000} +: CHAR_W];
  endfunction

endpackage

FILE: rtl/key_matrix_debounce_reporter.sv
// ----------------------------------------------------------------------------
// key_matrix_debounce_reporter
// Keypad matrix scanner with integrating debounce and change reports.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one transaction per sampled row,
//   carrying the row index and the column levels. Rows at or above the
//   configured row count are dropped.
//   Output channel (out_valid / out_stall): after the last row of a scan, if
//   the pressed map changed, one transaction per pressed cell in row-major
//   order; out_last_of_run marks the final one.
//   Config channel (cfg_valid / cfg_ready): always ready, write only while idle.
// Sequence:
//   Each row goes through the shared debounce unit one column per cycle. The
//   last row adds a compare state and, when the map changed, a walk over all
//   cells of the store, which pauses while the output is stalled.
//   in_stall stays high until that work is done.
// Reset: counters, pressed and previous maps clear; registers take defaults.
// A stalled receiver holds the output register and pauses the walk.
// ----------------------------------------------------------------------------
module key_matrix_debounce_reporter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [2:0]                     cfg_index,
  input  logic [63:0]                    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [kmd_pkg::ROW_W-1:0]      in_row_index,
  input  logic [kmd_pkg::MAX_COLS-1:0]   in_column_levels,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [kmd_pkg::CHAR_W-1:0]     out_key_char,
  output logic [kmd_pkg::CELL_W-1:0]     out_cell_index,
  output logic                           out_last_of_run
);

  logic [kmd_pkg::DIM_W-1:0] rows_r;
  logic [kmd_pkg::DIM_W-1:0] cols_r;
  logic [kmd_pkg::CNT_W-1:0] limit_r;
  logic [63:0]               char_low_r;
  logic [63:0]               char_high_r;
  logic                      cfg_we;
  kmd_pkg::cfg_t             cfg;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r      <= kmd_pkg::RST_ROWS;
      cols_r      <= kmd_pkg::RST_COLS;
      limit_r     <= kmd_pkg::RST_LIMIT;
      char_low_r  <= kmd_pkg::RST_CHAR_LOW;
      char_high_r <= kmd_pkg::RST_CHAR_HIGH;
    end else if (cfg_we) begin
      case (cfg_index)
        kmd_pkg::REG_ROWS:      rows_r      <= cfg_data[kmd_pkg::DIM_W-1:0];
        kmd_pkg::REG_COLS:      cols_r      <= cfg_data[kmd_pkg::DIM_W-1:0];
        kmd_pkg::REG_LIMIT:     limit_r     <= cfg_data[kmd_pkg::CNT_W-1:0];
        kmd_pkg::REG_CHAR_LOW:  char_low_r  <= cfg_data;
        kmd_pkg::REG_CHAR_HIGH: char_high_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Clamped view for the core
  assign cfg.rows     = kmd_pkg::clamp_count(rows_r, kmd_pkg::DIM_W'(kmd_pkg::MAX_ROWS));
  assign cfg.cols     = kmd_pkg::clamp_count(cols_r, kmd_pkg::DIM_W'(kmd_pkg::MAX_COLS));
  assign cfg.limit    = limit_r;
  assign cfg.char_map = {char_high_r, char_low_r};

  kmd_scan_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_row_index     (in_row_index),
    .in_column_levels (in_column_levels),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_key_char     (out_key_char),
    .out_cell_index   (out_cell_index),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

FILE: rtl/kmd_debounce_unit.sv
// ----------------------------------------------------------------------------
// kmd_debounce_unit
// Shared counter update and hysteresis compare for one matrix cell.
// ----------------------------------------------------------------------------
module kmd_debounce_unit (
  input  logic [kmd_pkg::CNT_W-1:0] cnt_in,
  input  logic                      level,
  input  logic [kmd_pkg::CNT_W-1:0] limit,
  input  logic                      pressed_in,
  output logic [kmd_pkg::CNT_W-1:0] cnt_out,
  output logic                      pressed_out
);

  logic [kmd_pkg::CNT_W:0]   cnt_inc;
  logic [kmd_pkg::CNT_W:0]   cnt_ext;
  logic [kmd_pkg::CNT_W-1:0] half;

  assign half    = limit >> 1;
  assign cnt_inc = {1'b0, cnt_in} + (kmd_pkg::CNT_W+1)'(1);

  // Up/down count, saturating at zero and at the limit
  always_comb begin
    if (level) begin
      cnt_out = (cnt_inc > {1'b0, limit}) ? limit : cnt_inc[kmd_pkg::CNT_W-1:0];
    end else begin
      cnt_out = (cnt_in == '0) ? '0 : cnt_in - kmd_pkg::CNT_W'(1);
    end
  end

  assign cnt_ext = {1'b0, cnt_out};

  // Hysteresis: press above half+1, release below half-1
  always_comb begin
    pressed_out = pressed_in;
    if (cnt_ext > ({1'b0, half} + (kmd_pkg::CNT_W+1)'(1))) begin
      pressed_out = 1'b1;
    end else if ((cnt_ext + (kmd_pkg::CNT_W+1)'(1)) < {1'b0, half}) begin
      pressed_out = 1'b0;
    end
  end

endmodule

FILE: rtl/kmd_scan_core.sv
// ----------------------------------------------------------------------------
// kmd_scan_core
// Sequencer over the cell store: per-column debounce, map compare, report walk.
// ----------------------------------------------------------------------------
module kmd_scan_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  kmd_pkg::cfg_t                  cfg,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [kmd_pkg::ROW_W-1:0]      in_row_index,
  input  logic [kmd_pkg::MAX_COLS-1:0]   in_column_levels,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [kmd_pkg::CHAR_W-1:0]     out_key_char,
  output logic [kmd_pkg::CELL_W-1:0]     out_cell_index,
  output logic                           out_last_of_run
);

  kmd_pkg::state_t state_r, state_nxt;

  logic [kmd_pkg::CNT_W-1:0]    cnt_r [kmd_pkg::CELLS];
  logic [kmd_pkg::CELLS-1:0]    pressed_r, pressed_nxt;
  logic [kmd_pkg::CELLS-1:0]    prev_r, prev_nxt;
  logic [kmd_pkg::ROW_W-1:0]    row_r, row_nxt;
  logic [kmd_pkg::MAX_COLS-1:0] levels_r, levels_nxt;
  logic [kmd_pkg::COL_W-1:0]    col_r, col_nxt;
  logic [kmd_pkg::CELL_W-1:0]   pos_r, pos_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [kmd_pkg::CHAR_W-1:0]   key_char_r, key_char_nxt;
  logic [kmd_pkg::CELL_W-1:0]   cell_index_r, cell_index_nxt;
  logic                         last_r, last_nxt;

  logic                         in_acc;
  logic [kmd_pkg::CELL_W-1:0]   upd_pos;
  logic [kmd_pkg::CNT_W-1:0]    upd_cnt;
  logic                         upd_pressed;
  logic                         cnt_we;
  logic [kmd_pkg::CELLS-1:0]    use_mask;
  logic [kmd_pkg::CELLS-1:0]    later_mask;
  logic                         hit;
  logic                         slot_free;
  logic [kmd_pkg::CELL_W:0]     idx_full;
  logic [kmd_pkg::CELL_W-1:0]   idx;

  assign in_stall = (state_r != kmd_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Cells inside the configured matrix
  always_comb begin
    for (int p = 0; p < kmd_pkg::CELLS; p++) begin
      use_mask[p] = ({1'b0, 2'(p / kmd_pkg::MAX_COLS)} < cfg.rows) &&
                    ({1'b0, 2'(p % kmd_pkg::MAX_COLS)} < cfg.cols);
    end
  end

  // Shared debounce unit, one column per cycle
  assign upd_pos = {row_r, col_r};

  kmd_debounce_unit u_debounce (
    .cnt_in      (cnt_r[upd_pos]),
    .level       (levels_r[col_r]),
    .limit       (cfg.limit),
    .pressed_in  (pressed_r[upd_pos]),
    .cnt_out     (upd_cnt),
    .pressed_out (upd_pressed)
  );

  // Report walk helpers
  assign hit        = pressed_r[pos_r] && use_mask[pos_r];
  assign slot_free  = !out_valid_r || !out_stall;
  assign later_mask = ({kmd_pkg::CELLS{1'b1}} << pos_r) << 1;
  assign idx_full   = (kmd_pkg::CELL_W+1)'(pos_r[3:2]) * (kmd_pkg::CELL_W+1)'(cfg.cols)
                    + (kmd_pkg::CELL_W+1)'(pos_r[1:0]);
  assign idx        = idx_full[kmd_pkg::CELL_W-1:0];

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    pressed_nxt    = pressed_r;
    prev_nxt       = prev_r;
    row_nxt        = row_r;
    levels_nxt     = levels_r;
    col_nxt        = col_r;
    pos_nxt        = pos_r;
    cnt_we         = 1'b0;
    out_valid_nxt  = out_valid_r && out_stall;
    key_char_nxt   = key_char_r;
    cell_index_nxt = cell_index_r;
    last_nxt       = last_r;
    case (state_r)
      kmd_pkg::ST_IDLE: begin
        if (in_acc && ({1'b0, in_row_index} < cfg.rows)) begin
          row_nxt    = in_row_index;
          levels_nxt = in_column_levels;
          col_nxt    = '0;
          state_nxt  = kmd_pkg::ST_UPDATE;
        end
      end
      kmd_pkg::ST_UPDATE: begin
        cnt_we               = 1'b1;
        pressed_nxt[upd_pos] = upd_pressed;
        col_nxt              = col_r + kmd_pkg::COL_W'(1);
        if ({1'b0, col_r} == cfg.cols - kmd_pkg::DIM_W'(1)) begin
          if ({1'b0, row_r} == cfg.rows - kmd_pkg::DIM_W'(1)) begin
            state_nxt = kmd_pkg::ST_CHECK;
          end else begin
            state_nxt = kmd_pkg::ST_IDLE;
          end
        end
      end
      kmd_pkg::ST_CHECK: begin
        if (|((pressed_r ^ prev_r) & use_mask)) begin
          prev_nxt  = (prev_r & ~use_mask) | (pressed_r & use_mask);
          pos_nxt   = '0;
          state_nxt = kmd_pkg::ST_WALK;
        end else begin
          state_nxt = kmd_pkg::ST_IDLE;
        end
      end
      kmd_pkg::ST_WALK: begin
        if (hit && slot_free) begin
          out_valid_nxt  = 1'b1;
          key_char_nxt   = kmd_pkg::char_of(cfg.char_map, idx);
          cell_index_nxt = idx;
          last_nxt       = ~|(pressed_r & use_mask & later_mask);
        end
        if (!hit || slot_free) begin
          pos_nxt = pos_r + kmd_pkg::CELL_W'(1);
          if (pos_r == kmd_pkg::CELL_W'(kmd_pkg::CELLS - 1)) begin
            state_nxt = kmd_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = kmd_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and cell state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kmd_pkg::ST_IDLE;
      pressed_r   <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
      for (int p = 0; p < kmd_pkg::CELLS; p++) begin
        cnt_r[p] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      pressed_r   <= pressed_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
      if (cnt_we) begin
        cnt_r[upd_pos] <= upd_cnt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    row_r        <= row_nxt;
    levels_r     <= levels_nxt;
    col_r        <= col_nxt;
    pos_r        <= pos_nxt;
    key_char_r   <= key_char_nxt;
    cell_index_r <= cell_index_nxt;
    last_r       <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_key_char    = key_char_r;
  assign out_cell_index  = cell_index_r;
  assign out_last_of_run = last_r;

endmodule

FILE: rtl/kmd_checker.sv
// ----------------------------------------------------------------------------
// kmd_checker
// Port-level checks of the key matrix debounce reporter, bound to the top.
// ----------------------------------------------------------------------------
module kmd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [kmd_pkg::CHAR_W-1:0]   out_key_char,
  input logic                         out_last_of_run
);

  // Reset leaves the block idle with nothing to report
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!in_stall && !out_valid))
    else $error("block not idle after reset");

  // A stalled result stays valid
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped under stall");

  // A stalled result keeps its character
  a_hold_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_key_char))
    else $error("result changed under stall");

  // More reports pending keeps the input side stalled
  a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_of_run) |-> in_stall)
    else $error("input taken in the middle of a report run");

endmodule

bind key_matrix_debounce_reporter kmd_checker u_kmd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_key_char    (out_key_char),
  .out_last_of_run (out_last_of_run)
);

FILE: test/key_matrix_debounce_reporter_checker.sv
// ----------------------------------------------------------------------------
// key_matrix_debounce_reporter_checker
// Watches the config, row and report channels of the key matrix scanner. It
// keeps its own copy of the debounce counters, the pressed map and the last
// reported map. Every accepted report transaction is compared field by field
// with the oldest predicted report.
// ----------------------------------------------------------------------------
module key_matrix_debounce_reporter_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [63:0]                   cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [kmd_pkg::ROW_W-1:0]     in_row_index,
  input  logic [kmd_pkg::MAX_COLS-1:0]  in_column_levels,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [kmd_pkg::CHAR_W-1:0]    out_key_char,
  input  logic [kmd_pkg::CELL_W-1:0]    out_cell_index,
  input  logic                          out_last_of_run,
  output int                            mismatch_count,
  output int                            reports_pending
);

  typedef struct packed {
    logic [kmd_pkg::CHAR_W-1:0] key_char;
    logic [kmd_pkg::CELL_W-1:0] cell_index;
    logic                       last_of_run;
  } key_report_t;

  // Predicted reports, oldest first
  key_report_t expected_reports[$];

  // Shadow registers
  logic [kmd_pkg::DIM_W-1:0] rows_reg;
  logic [kmd_pkg::DIM_W-1:0] cols_reg;
  logic [kmd_pkg::CNT_W-1:0] limit_reg;
  logic [63:0]               map_low_reg;
  logic [63:0]               map_high_reg;

  // Per-cell state, stored at row*MAX_COLS+col
  logic [kmd_pkg::CNT_W-1:0] debounce_cnt  [kmd_pkg::CELLS];
  logic                      key_down      [kmd_pkg::CELLS];
  logic                      last_reported [kmd_pkg::CELLS];

  int errors = 0;

  // Row/column count as the scanner uses it
  function automatic int dim_in_use(input logic [kmd_pkg::DIM_W-1:0] v, input int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic logic [kmd_pkg::CHAR_W-1:0] key_char_of(input int idx);
    if (idx < 8) return map_low_reg[idx*8 +: 8];
    return map_high_reg[(idx-8)*8 +: 8];
  endfunction

  task automatic restore_defaults();
    rows_reg     = kmd_pkg::RST_ROWS;
    cols_reg     = kmd_pkg::RST_COLS;
    limit_reg    = kmd_pkg::RST_LIMIT;
    map_low_reg  = kmd_pkg::RST_CHAR_LOW;
    map_high_reg = kmd_pkg::RST_CHAR_HIGH;
    for (int p = 0; p < kmd_pkg::CELLS; p++) begin
      debounce_cnt[p]  = '0;
      key_down[p]      = 1'b0;
      last_reported[p] = 1'b0;
    end
    expected_reports.delete();
  endtask

  task automatic write_register(input logic [2:0] index, input logic [63:0] data);
    case (index)
      kmd_pkg::REG_ROWS:      rows_reg     = data[2:0];
      kmd_pkg::REG_COLS:      cols_reg     = data[2:0];
      kmd_pkg::REG_LIMIT:     limit_reg    = data[3:0];
      kmd_pkg::REG_CHAR_LOW:  map_low_reg  = data;
      kmd_pkg::REG_CHAR_HIGH: map_high_reg = data;
      default: ;
    endcase
  endtask

  // One sampled row: integrate, resolve, and at scan end queue the reports
  task automatic debounce_row(input logic [1:0] row, input logic [3:0] levels);
    int n_rows, n_cols, lim, press_level, release_level, cnt, p;
    bit changed;
    int down_cells[$];
    key_report_t rep;
    n_rows        = dim_in_use(rows_reg, kmd_pkg::MAX_ROWS);
    n_cols        = dim_in_use(cols_reg, kmd_pkg::MAX_COLS);
    lim           = int'(limit_reg);
    press_level   = lim / 2 + 1;
    release_level = lim / 2 - 1;
    changed       = 1'b0;
    if (row >= n_rows) return;

    for (int c = 0; c < n_cols; c++) begin
      p   = row * kmd_pkg::MAX_COLS + c;
      cnt = int'(debounce_cnt[p]);
      if (levels[c]) begin
        cnt = cnt + 1;
        if (cnt > lim) cnt = lim;
      end else begin
        cnt = cnt - 1;
        if (cnt < 0) cnt = 0;
      end
      debounce_cnt[p] = cnt[kmd_pkg::CNT_W-1:0];
      if (cnt > press_level) key_down[p] = 1'b1;
      else if (cnt < release_level) key_down[p] = 1'b0;
    end
    if (row != n_rows - 1) return;

    // Scan end: report only when the map in use moved
    for (int r = 0; r < n_rows; r++)
      for (int c = 0; c < n_cols; c++)
        if (key_down[r*kmd_pkg::MAX_COLS+c] != last_reported[r*kmd_pkg::MAX_COLS+c])
          changed = 1'b1;
    if (!changed) return;

    for (int r = 0; r < n_rows; r++) begin
      for (int c = 0; c < n_cols; c++) begin
        p = r * kmd_pkg::MAX_COLS + c;
        last_reported[p] = key_down[p];
        if (key_down[p]) down_cells.push_back((r * n_cols + c) % 16);
      end
    end
    foreach (down_cells[i]) begin
      rep.key_char    = key_char_of(down_cells[i]);
      rep.cell_index  = down_cells[i][kmd_pkg::CELL_W-1:0];
      rep.last_of_run = (i == down_cells.size() - 1);
      expected_reports.push_back(rep);
    end
  endtask

  // Sample all channels at the rising edge
  always @(posedge clk) begin : monitor
    key_report_t want;
    if (!rst_n) begin
      restore_defaults();
    end else begin
      // Report transaction against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          errors++;
          $display("%0t: unexpected report, expected none, got char %h cell %0d last %0b",
                   $time, out_key_char, out_cell_index, out_last_of_run);
        end else begin
          want = expected_reports.pop_front();
          if (out_key_char !== want.key_char) begin
            errors++;
            $display("%0t: key_char expected %h got %h", $time, want.key_char, out_key_char);
          end
          if (out_cell_index !== want.cell_index) begin
            errors++;
            $display("%0t: cell_index expected %0d got %0d",
                     $time, want.cell_index, out_cell_index);
          end
          if (out_last_of_run !== want.last_of_run) begin
            errors++;
            $display("%0t: last_of_run expected %0b got %0b",
                     $time, want.last_of_run, out_last_of_run);
          end
        end
      end
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (in_valid && !in_stall) debounce_row(in_row_index, in_column_levels);
    end
    mismatch_count  <= errors;
    reports_pending <= expected_reports.size();
  end

endmodule

FILE: test/key_matrix_debounce_reporter_test.sv
// ----------------------------------------------------------------------------
// key_matrix_debounce_reporter_test
// Drives row samples and register writes into the key matrix scanner with
// random gaps and output stalls. A short directed scan sequence comes first,
// then phases of debounced key patterns under changing configurations. The
// checker beside the block predicts every report.
// ----------------------------------------------------------------------------
module key_matrix_debounce_reporter_test;

  localparam int         IDLE_LIMIT    = 2000;
  localparam int         SETTLE_CYCLES = 40;
  localparam int         ITEM_TARGET   = 350;
  localparam logic [2:0] REG_SPARE     = 3'd7;  // index with no register behind it

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [2:0]                    cfg_index;
  logic [63:0]                   cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  logic [kmd_pkg::ROW_W-1:0]     in_row_index;
  logic [kmd_pkg::MAX_COLS-1:0]  in_column_levels;
  logic                          out_valid;
  logic                          out_stall;
  logic [kmd_pkg::CHAR_W-1:0]    out_key_char;
  logic [kmd_pkg::CELL_W-1:0]    out_cell_index;
  logic                          out_last_of_run;

  int mismatch_count;
  int reports_pending;
  int idle_cycles = 0;
  int items_sent  = 0;
  bit quiet_phase = 1'b0;

  // Stimulus view of the geometry, clamped like the scanner does
  int cur_rows  = 3;
  int cur_cols  = 3;
  int cur_limit = 6;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  key_matrix_debounce_reporter i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_row_index     (in_row_index),
    .in_column_levels (in_column_levels),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_key_char     (out_key_char),
    .out_cell_index   (out_cell_index),
    .out_last_of_run  (out_last_of_run)
  );

  key_matrix_debounce_reporter_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_row_index     (in_row_index),
    .in_column_levels (in_column_levels),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_key_char     (out_key_char),
    .out_cell_index   (out_cell_index),
    .out_last_of_run  (out_last_of_run),
    .mismatch_count   (mismatch_count),
    .reports_pending  (reports_pending)
  );

  // Watchdog: too long without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Gap length: mostly none or short, now and then long
  function automatic int idle_len();
    int pick;
    if (quiet_phase) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver back-pressure
  initial begin : stall_gen
    int hold;
    out_stall = 1'b0;
    forever begin
      repeat ($urandom_range(1, 4)) @(negedge clk);
      hold = idle_len();
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // One row transaction; entered and left at a falling edge
  task automatic send_row(input logic [1:0] row, input logic [3:0] levels);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         = 1'b1;
    in_row_index     = row;
    in_column_levels = levels;
    do begin
      @(posedge clk);
    end while (in_stall);
    @(negedge clk);
    if (row < cur_rows) items_sent++;
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [63:0] data);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Wait for all reports, then let a scan that ends silently finish
  task automatic drain();
    in_valid = 1'b0;
    while (reports_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write every register; unused upper bits carry noise
  task automatic configure(input logic [2:0] rows, input logic [2:0] cols,
                           input logic [3:0] limit);
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    write_reg(kmd_pkg::REG_ROWS, {noise[63:3], rows});
    noise = {$urandom, $urandom};
    write_reg(kmd_pkg::REG_COLS, {noise[63:3], cols});
    noise = {$urandom, $urandom};
    write_reg(kmd_pkg::REG_LIMIT, {noise[63:4], limit});
    write_reg(kmd_pkg::REG_CHAR_LOW, {$urandom, $urandom});
    write_reg(kmd_pkg::REG_CHAR_HIGH, {$urandom, $urandom});
    cur_rows  = (rows == 0) ? 1 : ((rows > kmd_pkg::MAX_ROWS) ? kmd_pkg::MAX_ROWS : rows);
    cur_cols  = (cols == 0) ? 1 : ((cols > kmd_pkg::MAX_COLS) ? kmd_pkg::MAX_COLS : cols);
    cur_limit = limit;
  endtask

  // Held keys with bounce, plus stray and partial scans
  task automatic run_phase(input int budget);
    logic [3:0] held [4];
    logic [3:0] lv;
    int first, pick, last_row;
    first = items_sent;
    for (int r = 0; r < 4; r++) held[r] = 4'($urandom_range(0, 15));
    while (items_sent - first < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        for (int r = 0; r < cur_rows; r++) begin
          lv = held[r];
          if ($urandom_range(0, 9) == 0) lv = lv ^ (4'b0001 << $urandom_range(0, 3));
          send_row(2'(r), lv);
        end
        // keep patterns long enough to settle under the current limit
        if ($urandom_range(0, cur_limit + 2) == 0)
          held[$urandom_range(0, 3)] = 4'($urandom_range(0, 15));
      end else if (pick < 93) begin
        send_row(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
      end else begin
        last_row = $urandom_range(0, cur_rows - 1);
        for (int r = 0; r <= last_row; r++) send_row(2'(r), 4'($urandom_range(0, 15)));
      end
    end
  endtask

  initial begin : stimulus
    int phase;
    rst_n            = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_valid         = 1'b0;
    in_row_index     = '0;
    in_column_levels = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: a row beyond those in use, then one full scan
    send_row(2'd3, 4'hF);
    for (int r = 0; r < 3; r++) send_row(2'(r), 4'hF);
    drain();

    // Two rows of four: press, then release everything (map moves, no report)
    configure(3'd2, 3'd4, 4'd4);
    repeat (4) begin
      send_row(2'd0, 4'hF);
      send_row(2'd1, 4'hA);
    end
    repeat (4) begin
      send_row(2'd0, 4'h0);
      send_row(2'd1, 4'h0);
    end
    drain();

    // Configuration phases, extremes first
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0: configure(3'd4, 3'd4, 4'd15);
        1: configure(3'd1, 3'd1, 4'd3);
        2: begin
          configure(3'd0, 3'd7, 4'd0);
          write_reg(REG_SPARE, {$urandom, $urandom});
        end
        3: configure(3'd7, 3'd0, 4'd1);
        4: configure(3'd4, 3'd4, 4'd2);
        default: begin
          configure(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                    ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                : 4'($urandom_range(3, 8)));
        end
      endcase
      quiet_phase = ($urandom_range(0, 3) == 0);
      run_phase($urandom_range(25, 45));
      quiet_phase = 1'b0;
      drain();
      phase++;
    end

    if (mismatch_count == 0 && reports_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
